// ----- src/wsp_pkg.sv -----
package wsp_pkg;

  // State geometry
  localparam int NCOMP = 37;
  localparam int COMP_W = 7;
  localparam int IDX_W = 6;
  localparam int RATE_W = 64;
  localparam int RATE_COMPS = 9;
  localparam int RC_ROUNDS = 111;
  localparam int ROUND_COUNT_DEF = 111;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [NCOMP-1:0][COMP_W-1:0] state_t;

  // Item commands
  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_ABSORB   = 3'd1,
    CMD_SET_RATE = 3'd2,
    CMD_PERMUTE  = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  // Components that carry the rate, MSB first; bit 6 of the last component follows
  localparam int RATE_POS [RATE_COMPS] = '{8, 9, 15, 16, 18, 27, 28, 34, 35};
  localparam int LAST_COMP = NCOMP - 1;

  localparam comp_t OMEGA_POLY = 7'h78;

  localparam comp_t WGP_TAB [128] = '{
    7'h00, 7'h12, 7'h0a, 7'h4b, 7'h66, 7'h0c, 7'h48, 7'h73, 7'h79, 7'h3e, 7'h61, 7'h51,
    7'h01, 7'h15, 7'h17, 7'h0e, 7'h7e, 7'h33, 7'h68, 7'h36, 7'h42, 7'h35, 7'h37, 7'h5e,
    7'h53, 7'h4c, 7'h3f, 7'h54, 7'h58, 7'h6e, 7'h56, 7'h2a, 7'h1d, 7'h25, 7'h6d, 7'h65,
    7'h5b, 7'h71, 7'h2f, 7'h20, 7'h06, 7'h18, 7'h29, 7'h3a, 7'h0d, 7'h7a, 7'h6c, 7'h1b,
    7'h19, 7'h43, 7'h70, 7'h41, 7'h49, 7'h22, 7'h77, 7'h60, 7'h4f, 7'h45, 7'h55, 7'h02,
    7'h63, 7'h47, 7'h75, 7'h2d, 7'h40, 7'h46, 7'h7d, 7'h5c, 7'h7c, 7'h59, 7'h26, 7'h0b,
    7'h09, 7'h03, 7'h57, 7'h5d, 7'h27, 7'h78, 7'h30, 7'h2e, 7'h44, 7'h52, 7'h3b, 7'h08,
    7'h67, 7'h2c, 7'h05, 7'h6b, 7'h2b, 7'h1a, 7'h21, 7'h38, 7'h07, 7'h0f, 7'h4a, 7'h11,
    7'h50, 7'h6a, 7'h28, 7'h31, 7'h10, 7'h4d, 7'h5f, 7'h72, 7'h39, 7'h16, 7'h5a, 7'h13,
    7'h04, 7'h3c, 7'h34, 7'h1f, 7'h76, 7'h1e, 7'h14, 7'h23, 7'h1c, 7'h32, 7'h4e, 7'h7b,
    7'h24, 7'h74, 7'h7f, 7'h3d, 7'h69, 7'h64, 7'h62, 7'h6f
  };

  // Round constants, two per round: even entry for s19, odd entry for feedback
  localparam comp_t RC_TAB [RC_ROUNDS*2] = '{
    7'h7f, 7'h3f, 7'h1f, 7'h0f, 7'h07, 7'h03, 7'h01, 7'h40, 7'h20, 7'h10, 7'h08, 7'h04,
    7'h02, 7'h41, 7'h60, 7'h30, 7'h18, 7'h0c, 7'h06, 7'h43, 7'h21, 7'h50, 7'h28, 7'h14,
    7'h0a, 7'h45, 7'h62, 7'h71, 7'h78, 7'h3c, 7'h1e, 7'h4f, 7'h27, 7'h13, 7'h09, 7'h44,
    7'h22, 7'h51, 7'h68, 7'h34, 7'h1a, 7'h4d, 7'h66, 7'h73, 7'h39, 7'h5c, 7'h2e, 7'h57,
    7'h2b, 7'h15, 7'h4a, 7'h65, 7'h72, 7'h79, 7'h7c, 7'h3e, 7'h5f, 7'h2f, 7'h17, 7'h0b,
    7'h05, 7'h42, 7'h61, 7'h70, 7'h38, 7'h1c, 7'h0e, 7'h47, 7'h23, 7'h11, 7'h48, 7'h24,
    7'h12, 7'h49, 7'h64, 7'h32, 7'h59, 7'h6c, 7'h36, 7'h5b, 7'h2d, 7'h56, 7'h6b, 7'h35,
    7'h5a, 7'h6d, 7'h76, 7'h7b, 7'h3d, 7'h5e, 7'h6f, 7'h37, 7'h1b, 7'h0d, 7'h46, 7'h63,
    7'h31, 7'h58, 7'h2c, 7'h16, 7'h4b, 7'h25, 7'h52, 7'h69, 7'h74, 7'h3a, 7'h5d, 7'h6e,
    7'h77, 7'h3b, 7'h1d, 7'h4e, 7'h67, 7'h33, 7'h19, 7'h4c, 7'h26, 7'h53, 7'h29, 7'h54,
    7'h2a, 7'h55, 7'h6a, 7'h75, 7'h7a, 7'h7d, 7'h7e, 7'h7f, 7'h3f, 7'h1f, 7'h0f, 7'h07,
    7'h03, 7'h01, 7'h40, 7'h20, 7'h10, 7'h08, 7'h04, 7'h02, 7'h41, 7'h60, 7'h30, 7'h18,
    7'h0c, 7'h06, 7'h43, 7'h21, 7'h50, 7'h28, 7'h14, 7'h0a, 7'h45, 7'h62, 7'h71, 7'h78,
    7'h3c, 7'h1e, 7'h4f, 7'h27, 7'h13, 7'h09, 7'h44, 7'h22, 7'h51, 7'h68, 7'h34, 7'h1a,
    7'h4d, 7'h66, 7'h73, 7'h39, 7'h5c, 7'h2e, 7'h57, 7'h2b, 7'h15, 7'h4a, 7'h65, 7'h72,
    7'h79, 7'h7c, 7'h3e, 7'h5f, 7'h2f, 7'h17, 7'h0b, 7'h05, 7'h42, 7'h61, 7'h70, 7'h38,
    7'h1c, 7'h0e, 7'h47, 7'h23, 7'h11, 7'h48, 7'h24, 7'h12, 7'h49, 7'h64, 7'h32, 7'h59,
    7'h6c, 7'h36, 7'h5b, 7'h2d, 7'h56, 7'h6b, 7'h35, 7'h5a, 7'h6d, 7'h76, 7'h7b, 7'h3d,
    7'h5e, 7'h6f, 7'h37, 7'h1b, 7'h0d, 7'h46
  };

  function automatic comp_t wgp(input comp_t v);
    return WGP_TAB[v];
  endfunction

  // omega: multiply by x in the 7-bit field, written as a right shift
  function automatic comp_t omega(input comp_t v);
    return (v >> 1) ^ (v[0] ? OMEGA_POLY : 7'h00);
  endfunction

  // Bit-sliced 7-bit S-box
  function automatic comp_t sbox7(input comp_t v);
    logic a0, a1, a2, a3, a4, a5, a6;
    a0 = v[6]; a1 = v[5]; a2 = v[4]; a3 = v[3]; a4 = v[2]; a5 = v[1]; a6 = v[0];
    a0 ^= (a2 & a3); a3 = ~a3; a3 ^= (a5 & a6); a5 = ~a5; a5 ^= (a2 & a4);
    a6 ^= (a0 & a4); a4 = ~a4; a4 ^= (a5 & a1); a5 = ~a5; a5 ^= (a0 & a2);
    a1 ^= (a6 & a2); a2 = ~a2; a2 ^= (a5 & a3); a5 = ~a5; a5 ^= (a6 & a0);
    a3 ^= (a1 & a0); a0 = ~a0; a0 ^= (a5 & a4); a5 = ~a5; a5 ^= (a1 & a6);
    a4 ^= (a3 & a6); a6 = ~a6; a6 ^= (a5 & a2); a5 = ~a5; a5 ^= (a3 & a1);
    a2 ^= (a4 & a1); a1 = ~a1; a1 ^= (a5 & a0); a5 = ~a5; a5 ^= (a4 & a3);
    a2 = ~a2; a4 = ~a4;
    return {a2, a6, a4, a1, a3, a5, a0};
  endfunction

  // Pack the rate components into one word, first component on top
  function automatic logic [RATE_W-1:0] pack_rate(input state_t s);
    logic [RATE_W-1:0] w;
    w = '0;
    for (int j = 0; j < RATE_COMPS; j++) begin
      w[RATE_W-1-COMP_W*j -: COMP_W] = s[RATE_POS[j]];
    end
    w[0] = s[LAST_COMP][COMP_W-1];
    return w;
  endfunction

endpackage

// ----- src/wsp_round.sv -----
module wsp_round #(
  parameter int ROUND_COUNT = wsp_pkg::ROUND_COUNT_DEF
) (
  input  wsp_pkg::state_t                     st_i,
  input  logic [$clog2(ROUND_COUNT)-1:0]      rnd_i,
  output wsp_pkg::state_t                     st_o
);
  import wsp_pkg::*;

  logic [7:0] k_even;
  logic [7:0] k_odd;
  comp_t      fb;
  state_t     t;

  // Round constant addresses
  assign k_even = {7'(rnd_i), 1'b0};
  assign k_odd  = {7'(rnd_i), 1'b1};

  // One WAGE round: feedback, nonlinear taps, then shift down by one component
  always_comb begin
    fb = omega(st_i[0]) ^ st_i[6] ^ st_i[8] ^ st_i[12] ^ st_i[13] ^ st_i[19]
       ^ st_i[24] ^ st_i[26] ^ st_i[30] ^ st_i[31] ^ RC_TAB[k_odd]
       ^ wgp(st_i[LAST_COMP]);
    t = st_i;
    t[5]  = st_i[5]  ^ sbox7(st_i[8]);
    t[11] = st_i[11] ^ sbox7(st_i[15]);
    t[19] = st_i[19] ^ wgp(st_i[18]) ^ RC_TAB[k_even];
    t[24] = st_i[24] ^ sbox7(st_i[27]);
    t[30] = st_i[30] ^ sbox7(st_i[34]);
    st_o = {fb, t[NCOMP-1:1]};
  end

endmodule

// ----- src/wage_sponge_permutation.sv -----
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | command, data_word, domain_bits,
//         |           |                     | comp_index, comp_value
// out_    | output    | out_valid/out_ready | rate_word, comp_out
//
// A permute item is accepted, then steps through every round in the shared round
// unit, then loads the result register.
// Every other command goes through accept and state update, then result load.
// Reset (rst_n low, synchronous) clears all 37 components and the sequencer.
// in_ready is high only while idle and the result register is free or being taken.
// A stall on out_ready holds the result and blocks the next item.
module wage_sponge_permutation #(
  parameter int ROUND_COUNT = wsp_pkg::ROUND_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic [wsp_pkg::RATE_W-1:0]   in_data_word,
  input  logic [wsp_pkg::COMP_W-1:0]   in_domain_bits,
  input  logic [wsp_pkg::IDX_W-1:0]    in_comp_index,
  input  logic [wsp_pkg::COMP_W-1:0]   in_comp_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wsp_pkg::RATE_W-1:0]   out_rate_word,
  output logic [wsp_pkg::COMP_W-1:0]   out_comp_out
);
  import wsp_pkg::*;

  localparam int RND_W = $clog2(ROUND_COUNT);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RPT
  } fsm_t;

  fsm_t              st_r, st_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  state_t            comp_r, comp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;
  comp_t             out_comp_r, out_comp_nxt;
  state_t            round_st;
  logic              in_fire;
  logic [RATE_W-1:0] w;

  // Shared round unit
  wsp_round #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_round (
    .st_i  (comp_r),
    .rnd_i (rnd_r),
    .st_o  (round_st)
  );

  assign in_ready = (st_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign w        = in_data_word;

  // Sequencer and state update
  always_comb begin
    st_nxt        = st_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r;
    out_rate_nxt  = out_rate_r;
    out_comp_nxt  = out_comp_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = in_comp_index;
          st_nxt  = ST_RPT;
          case (cmd_t'(in_command))
            CMD_WRITE: begin
              for (int i = 0; i < NCOMP; i++) begin
                if (in_comp_index == IDX_W'(i)) begin
                  comp_nxt[i] = in_comp_value;
                end
              end
            end
            CMD_ABSORB: begin
              for (int j = 0; j < RATE_COMPS; j++) begin
                comp_nxt[RATE_POS[j]] = comp_r[RATE_POS[j]]
                                      ^ w[RATE_W-1-COMP_W*j -: COMP_W];
              end
              comp_nxt[LAST_COMP][COMP_W-1] = comp_r[LAST_COMP][COMP_W-1] ^ w[0];
              comp_nxt[0] = comp_r[0] ^ in_domain_bits;
            end
            CMD_SET_RATE: begin
              for (int j = 0; j < RATE_COMPS; j++) begin
                comp_nxt[RATE_POS[j]] = w[RATE_W-1-COMP_W*j -: COMP_W];
              end
              comp_nxt[LAST_COMP][COMP_W-1] = w[0];
              comp_nxt[0] = comp_r[0] ^ in_domain_bits;
            end
            CMD_PERMUTE: begin
              st_nxt  = ST_RUN;
              rnd_nxt = '0;
            end
            CMD_READ: begin
              st_nxt = ST_RPT;
            end
            default: begin
              st_nxt = ST_RPT;
            end
          endcase
        end
      end
      ST_RUN: begin
        comp_nxt = round_st;
        if (rnd_r == RND_LAST) begin
          st_nxt = ST_RPT;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      ST_RPT: begin
        // Result slot is free here: it was free or taken when the item entered
        out_valid_nxt = 1'b1;
        out_rate_nxt  = pack_rate(comp_r);
        out_comp_nxt  = '0;
        for (int i = 0; i < NCOMP; i++) begin
          if (idx_r == IDX_W'(i)) begin
            out_comp_nxt = comp_r[i];
          end
        end
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rnd_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
      out_rate_r  <= out_rate_nxt;
      out_comp_r  <= out_comp_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rate_word = out_rate_r;
  assign out_comp_out  = out_comp_r;

  // A permute item starts the round sequence at round zero
  a_perm_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_PERMUTE) |=> (st_r == ST_RUN) && (rnd_r == '0))
    else $error("permute did not start at round zero");

  // Any other command goes straight to the result load
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command != CMD_PERMUTE) |=> (st_r == ST_RPT))
    else $error("short command did not go to result load");

  // A result appears only from the result-load step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_RPT))
    else $error("result raised outside result load");

endmodule
